@@ rtl/core/fis_pkg.sv @@
// ----------------------------------------------------------------------------
// fis_pkg
// Types and constants shared by the frame interval statistics block.
// ----------------------------------------------------------------------------
package fis_pkg;

    localparam int unsigned STAMP_W  = 48;
    localparam int unsigned TALLY_W  = 16;
    localparam int unsigned SUM_W    = 40;
    localparam int unsigned GAP_W    = 32;
    localparam int unsigned PERIOD_W = 32;
    localparam int unsigned PADDR_W  = 3;
    localparam int unsigned PDATA_W  = 32;

    // register map, decoded on word address bit
    localparam logic REG_PERIOD = 1'b0;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd1000000;

    typedef struct packed {
        logic               frame_ok;
        logic [STAMP_W-1:0] frame_time_us;
        logic [STAMP_W-1:0] now_us;
    } t_frame_event;

    typedef struct packed {
        logic [TALLY_W-1:0] delivered_count;
        logic [TALLY_W-1:0] failed_count;
        logic [STAMP_W-1:0] window_length_us;
        logic [SUM_W-1:0]   gap_total_us;
        logic [GAP_W-1:0]   gap_least_us;
        logic [GAP_W-1:0]   gap_most_us;
    } t_frame_report;

endpackage

@@ rtl/core/frame_interval_statistics.sv @@
// ----------------------------------------------------------------------------
// frame_interval_statistics
// Frame rate monitor: window tallies of frame events and frame gaps.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready / i_event) carries one frame event per
//   item: delivered flag, capture stamp and current time in microseconds.
//   Output channel (o_valid / i_ready / o_report) carries one report item
//   each time the elapsed window reaches report_period_us; other events give
//   no report. The APB port holds report_period_us at byte address 0.
//   An accepted event is held in the input register until the update stage
//   folds it into the window state; its report, if any, is shown from then on.
//   Throughput: one event per cycle while no report waits on i_ready.
//   Events are registered, then folded into the window state by one stage
//   of adds and compares that also loads the report register.
//   Reset: window start, last stamp and all tallies clear, period returns
//   to 1000000 us, both channels go empty.
//   Stall: while a report waits on i_ready, the registered event is held and
//   o_ready drops once the input register is full as well. A taken report
//   frees the stage in the same cycle.
// ----------------------------------------------------------------------------
module frame_interval_statistics
    import fis_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // frame events
    input  logic                i_valid,
    output logic                o_ready,
    input  t_frame_event        i_event,
    // reports
    output logic                o_valid,
    input  logic                i_ready,
    output t_frame_report       o_report,
    // APB configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    // input register
    logic                r_in_valid;
    t_frame_event        r_in;

    // window state
    logic [PERIOD_W-1:0] r_period;
    logic [STAMP_W-1:0]  r_window_start;
    logic [STAMP_W-1:0]  r_prev_stamp;
    logic [TALLY_W-1:0]  r_delivered;
    logic [TALLY_W-1:0]  r_failed;
    logic [SUM_W-1:0]    r_gap_sum;
    logic [GAP_W-1:0]    r_gap_min;
    logic [GAP_W-1:0]    r_gap_max;

    // report register
    logic                r_out_valid;
    t_frame_report       r_out;

    // update stage
    logic                w_fire;
    logic                w_has_gap;
    logic [STAMP_W-1:0]  w_gap;
    logic [GAP_W-1:0]    w_gap32;
    logic [SUM_W:0]      w_sum_wide;
    logic [SUM_W-1:0]    n_gap_sum;
    logic [GAP_W-1:0]    n_gap_min;
    logic [GAP_W-1:0]    n_gap_max;
    logic [TALLY_W-1:0]  n_delivered;
    logic [TALLY_W-1:0]  n_failed;
    logic [STAMP_W-1:0]  w_elapsed;
    logic                w_report;
    logic                w_cfg_wr;

    // stage advances when the report register is free or being emptied
    assign w_fire  = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_fire;

    // ---------------- APB ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_PERIOD);
    assign prdata   = (paddr[PADDR_W-1] == REG_PERIOD) ? r_period : '0;

    // ---------------- tally and gap update ----------------
    always_comb begin
        n_delivered = r_delivered;
        n_failed    = r_failed;
        if (r_in.frame_ok) begin
            if (r_delivered != '1) n_delivered = r_delivered + 1'b1;
        end else begin
            if (r_failed != '1) n_failed = r_failed + 1'b1;
        end

        // a stored stamp of zero means no earlier frame
        w_has_gap  = r_in.frame_ok && (r_prev_stamp != '0) &&
                     (r_in.frame_time_us > r_prev_stamp);
        w_gap      = r_in.frame_time_us - r_prev_stamp;
        w_gap32    = (|w_gap[STAMP_W-1:GAP_W]) ? '1 : w_gap[GAP_W-1:0];
        // gap above the sum width saturates the sum on its own
        w_sum_wide = {1'b0, r_gap_sum} + {1'b0, w_gap[SUM_W-1:0]};

        n_gap_sum = r_gap_sum;
        n_gap_min = r_gap_min;
        n_gap_max = r_gap_max;
        if (w_has_gap) begin
            if (w_sum_wide[SUM_W] || (|w_gap[STAMP_W-1:SUM_W])) n_gap_sum = '1;
            else                                                 n_gap_sum = w_sum_wide[SUM_W-1:0];
            if ((r_gap_min == '0) || (w_gap32 < r_gap_min)) n_gap_min = w_gap32;
            if (w_gap32 > r_gap_max)                        n_gap_max = w_gap32;
        end

        // time before the window start is a negative elapsed time: no report
        w_elapsed = r_in.now_us - r_window_start;
        w_report  = (r_in.now_us >= r_window_start) &&
                    (w_elapsed >= {{(STAMP_W-PERIOD_W){1'b0}}, r_period});
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_period       <= PERIOD_RESET;
            r_window_start <= '0;
            r_prev_stamp   <= '0;
            r_delivered    <= '0;
            r_failed       <= '0;
            r_gap_sum      <= '0;
            r_gap_min      <= '0;
            r_gap_max      <= '0;
        end else begin
            if (w_cfg_wr) r_period <= pwdata[PERIOD_W-1:0];

            if (o_ready) r_in_valid <= i_valid;

            if (r_out_valid && i_ready) r_out_valid <= 1'b0;

            if (w_fire) begin
                if (r_in.frame_ok) r_prev_stamp <= r_in.frame_time_us;
                if (w_report) begin
                    r_out_valid    <= 1'b1;
                    r_window_start <= r_in.now_us;
                    r_delivered    <= '0;
                    r_failed       <= '0;
                    r_gap_sum      <= '0;
                    r_gap_min      <= '0;
                    r_gap_max      <= '0;
                end else begin
                    r_delivered    <= n_delivered;
                    r_failed       <= n_failed;
                    r_gap_sum      <= n_gap_sum;
                    r_gap_min      <= n_gap_min;
                    r_gap_max      <= n_gap_max;
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_in <= i_event;
        if (w_fire && w_report) begin
            r_out.delivered_count  <= n_delivered;
            r_out.failed_count     <= n_failed;
            r_out.window_length_us <= w_elapsed;
            r_out.gap_total_us     <= n_gap_sum;
            r_out.gap_least_us     <= n_gap_min;
            r_out.gap_most_us      <= n_gap_max;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_report = r_out;

    // ---------------- assertions ----------------
    a_clear_after_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_report) |=> (r_delivered == '0 && r_failed == '0 && r_gap_sum == '0))
        else $error("window tallies not cleared after report");

    a_min_max_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gap_min == '0) == (r_gap_max == '0))
        else $error("gap min and max disagree on gap presence");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gap_min != '0) |-> (r_gap_min <= r_gap_max))
        else $error("gap min above gap max");

    a_sum_covers_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gap_sum >= {{(SUM_W-GAP_W){1'b0}}, r_gap_max})
        else $error("gap sum below largest gap");

    a_held_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_fire) |=> (r_in_valid && $stable(r_in)))
        else $error("stalled event lost or changed");

endmodule

@@ tb/tb_frame_interval_statistics.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_frame_interval_statistics
// Self-checking bench for the frame interval statistics block. A
// cycle-free model of the window tallies predicts every report. Directed
// frames cover the corner cases, including the longest period. Random
// phases at several report periods follow, with random idling on both
// channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_frame_interval_statistics;
    import fis_pkg::*;

    // the period register sits at word 0 of the config space
    localparam logic [PADDR_W-1:0]  PERIOD_ADDR = {REG_PERIOD, 2'b00};
    localparam logic [PERIOD_W-1:0] PERIOD_MAX  = {PERIOD_W{1'b1}};
    localparam longint unsigned     GAP_CAP     = (64'd1 << GAP_W) - 1;
    localparam longint unsigned     SUM_CAP     = (64'd1 << SUM_W) - 1;
    localparam int unsigned         PHASE_ITEMS = 105;

    // ------------------------------------------------------------------------
    // Window model plus the queue of reports still owed by the block
    // ------------------------------------------------------------------------
    class window_report_tracker;
        logic [PERIOD_W-1:0] period;
        logic [STAMP_W-1:0]  win_start;
        logic [STAMP_W-1:0]  last_stamp;
        logic [TALLY_W-1:0]  delivered;
        logic [TALLY_W-1:0]  failed;
        logic [SUM_W-1:0]    gap_sum;
        logic [GAP_W-1:0]    gap_min;
        logic [GAP_W-1:0]    gap_max;
        t_frame_report       owed_reports[$];
        int unsigned         mismatches;

        function new();
            period     = PERIOD_RESET;
            win_start  = '0;
            last_stamp = '0;
            mismatches = 0;
            clear_window();
        endfunction

        function void clear_window();
            delivered = '0;
            failed    = '0;
            gap_sum   = '0;
            gap_min   = '0;
            gap_max   = '0;
        endfunction

        function void set_period(logic [PERIOD_W-1:0] value);
            period = value;
        endfunction

        // fold one accepted frame event in; queue a report if the window closes
        function void note_event(t_frame_event ev);
            longint unsigned    gap;
            longint unsigned    total;
            logic [GAP_W-1:0]   gap_clip;
            logic [STAMP_W-1:0] elapsed;
            t_frame_report      rep;
            if (!ev.frame_ok) begin
                if (failed != '1) failed = failed + 1'b1;
            end else begin
                if (delivered != '1) delivered = delivered + 1'b1;
                // zero stamp means no earlier frame; equal or older stamps add no gap
                if (last_stamp != '0 && ev.frame_time_us > last_stamp) begin
                    gap      = 64'(ev.frame_time_us) - 64'(last_stamp);
                    gap_clip = (gap > GAP_CAP) ? '1 : gap[GAP_W-1:0];
                    total    = 64'(gap_sum) + gap;
                    gap_sum  = (total > SUM_CAP) ? '1 : total[SUM_W-1:0];
                    if (gap_min == '0 || gap_clip < gap_min) gap_min = gap_clip;
                    if (gap_clip > gap_max) gap_max = gap_clip;
                end
                last_stamp = ev.frame_time_us;
            end
            // time behind the window start counts as negative: no report
            if (ev.now_us < win_start) return;
            elapsed = ev.now_us - win_start;
            if (elapsed < period) return;
            rep.delivered_count  = delivered;
            rep.failed_count     = failed;
            rep.window_length_us = elapsed;
            rep.gap_total_us     = gap_sum;
            rep.gap_least_us     = gap_min;
            rep.gap_most_us      = gap_max;
            owed_reports.push_back(rep);
            win_start = ev.now_us;
            clear_window();
        endfunction

        task flag_mismatch(string msg);
            $display("mismatch at %0t ns: %s", $time, msg);
            mismatches++;
        endtask

        task compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
                flag_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
        endtask

        task check_report(t_frame_report got);
            t_frame_report want;
            if (owed_reports.size() == 0) begin
                flag_mismatch($sformatf("report with none owed, window %0d us",
                                        got.window_length_us));
                return;
            end
            want = owed_reports.pop_front();
            compare_field("delivered_count",  64'(want.delivered_count),
                          64'(got.delivered_count));
            compare_field("failed_count",     64'(want.failed_count),
                          64'(got.failed_count));
            compare_field("window_length_us", 64'(want.window_length_us),
                          64'(got.window_length_us));
            compare_field("gap_total_us",     64'(want.gap_total_us),
                          64'(got.gap_total_us));
            compare_field("gap_least_us",     64'(want.gap_least_us),
                          64'(got.gap_least_us));
            compare_field("gap_most_us",      64'(want.gap_most_us),
                          64'(got.gap_most_us));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    t_frame_event        i_event = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    t_frame_report       o_report;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [PDATA_W-1:0]  pwdata  = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    window_report_tracker tracker;

    // idling controls: a calm side never pauses; hold_cycles asks the
    // report side for one long stall
    bit          sender_calm   = 1'b0;
    bit          receiver_calm = 1'b0;
    int unsigned hold_cycles   = 0;

    // running time and stamp of the random frame stream
    logic [STAMP_W-1:0] flow_now   = '0;
    logic [STAMP_W-1:0] flow_stamp = '0;

    frame_interval_statistics DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_event  (i_event),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_report (o_report),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Frame side
    // ------------------------------------------------------------------------
    function automatic t_frame_event make_frame(logic ok, logic [STAMP_W-1:0] stamp,
                                                logic [STAMP_W-1:0] now);
        t_frame_event ev;
        ev.frame_ok      = ok;
        ev.frame_time_us = stamp;
        ev.now_us        = now;
        return ev;
    endfunction

    // Mostly a well-formed stream: stamps climbing by small gaps and time
    // moving forward by up to about a third of the period per item, so that a
    // window closes every few items. Sprinkled in: failed grabs with junk
    // stamps, repeated, older and zero stamps, huge gaps, far time jumps
    // and times behind the window start.
    function automatic t_frame_event random_frame();
        t_frame_event    ev;
        longint unsigned span;
        int unsigned     roll;
        roll        = $urandom_range(0, 31);
        ev.frame_ok = (roll >= 4);
        if (!ev.frame_ok) begin
            ev.frame_time_us = STAMP_W'({$urandom, $urandom});
        end else begin
            case ($urandom_range(0, 15))
                0:       ev.frame_time_us = flow_stamp;
                1:       ev.frame_time_us = flow_stamp - $urandom_range(1, 5000);
                2:       ev.frame_time_us = '0;
                3:       ev.frame_time_us = STAMP_W'(64'(flow_stamp) + (64'd1 << 32) +
                                                     64'($urandom_range(0, 999)));
                4:       ev.frame_time_us = STAMP_W'({$urandom, $urandom});
                default: ev.frame_time_us = flow_stamp + $urandom_range(1, 5000);
            endcase
            flow_stamp = ev.frame_time_us;
        end

        if (flow_now < tracker.win_start) flow_now = tracker.win_start;
        span = 64'(tracker.period) / 3 + 2;
        roll = $urandom_range(0, 31);
        if (roll == 0) begin
            // far jump, kept clear of the top so time can still advance
            ev.now_us = STAMP_W'((64'($urandom_range(0, 32'hFF00)) << 32) | 64'($urandom));
        end else if (roll == 1 && tracker.win_start > 1000) begin
            ev.now_us = tracker.win_start - $urandom_range(1, 1000);
        end else begin
            flow_now  = flow_now + STAMP_W'({$urandom, $urandom} % span);
            ev.now_us = flow_now;
        end
        return ev;
    endfunction

    // offer one item, optionally after a random pause; valid stays up
    // across back-to-back items
    task automatic send_event(t_frame_event ev);
        int unsigned pause;
        pause = sender_calm ? 0 : $urandom_range(0, 9);
        if (pause != 0) begin
            i_valid <= 1'b0;
            repeat (pause) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_event <= ev;
        do @(posedge i_clk); while (!o_ready);
        tracker.note_event(ev);
    endtask

    // stop offering, wait for every owed report, then let the pipe settle
    // (an event in flight may still give no report)
    task automatic drain();
        i_valid <= 1'b0;
        while (tracker.owed_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write of the period, then a back-to-back read to check it stuck
    task automatic program_period(logic [PERIOD_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PERIOD_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        tracker.compare_field("report_period_us readback", 64'(value), 64'(prdata));
        tracker.set_period(value);
    endtask

    task automatic run_phase(logic [PERIOD_W-1:0] value, bit s_calm, bit r_calm,
                             int unsigned hold);
        program_period(value);
        sender_calm   = s_calm;
        receiver_calm = r_calm;
        hold_cycles   = hold;
        repeat (PHASE_ITEMS) send_event(random_frame());
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Report side: random ready stalls, one long hold on request
    // ------------------------------------------------------------------------
    initial begin : report_sink
        int unsigned stall;
        wait (i_rst_n);
        forever begin
            if (hold_cycles != 0) begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end else begin
                stall = receiver_calm ? 0 : $urandom_range(0, 9);
            end
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            tracker.check_report(o_report);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [STAMP_W-1:0] base;
        tracker = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed frames at the reset period of one second
        send_event(make_frame(1'b0, '1, 48'd10));              // failed grab, junk stamp
        send_event(make_frame(1'b1, 48'd100, 48'd20));         // first stamp: no gap
        send_event(make_frame(1'b1, 48'd100, 48'd30));         // same stamp again
        send_event(make_frame(1'b1, 48'd50, 48'd40));          // stamp goes back
        send_event(make_frame(1'b1, 48'd1050, 48'd50));        // gap 1000
        send_event(make_frame(1'b1, 48'd1060, 48'd60));        // gap 10, new minimum
        send_event(make_frame(1'b1, 48'd1060 + (48'd1 << 33), 48'd70)); // gap over 32 bits
        send_event(make_frame(1'b1, '1, 48'd999_999));         // gap sum saturates
        send_event(make_frame(1'b0, '0, 48'd1_000_000));       // window closes exactly
        send_event(make_frame(1'b0, '0, 48'd5));               // behind window start
        send_event(make_frame(1'b1, '0, 48'd1_500_000));       // zero stamp stored
        send_event(make_frame(1'b1, 48'd7, 48'd1_600_000));    // after zero: no gap
        send_event(make_frame(1'b1, 48'd8, 48'd2_000_000));    // gap 1, report
        send_event(make_frame(1'b1, 48'd8 + 48'hFFFF_FFFF, 48'd2_000_001)); // gap at 32-bit top
        send_event(make_frame(1'b1, 48'd8 + 48'h1_FFFF_FFFF, 48'd3_000_000)); // just over
        drain();

        // shortest nonzero period, then period zero
        program_period(32'd1);
        send_event(make_frame(1'b0, '0, 48'd3_000_000));       // elapsed zero: no report
        send_event(make_frame(1'b1, 48'd20, 48'd3_000_001));
        drain();
        program_period('0);
        send_event(make_frame(1'b0, '0, 48'd3_000_001));       // reports on zero elapsed
        send_event(make_frame(1'b0, '0, 48'd3_000_000));       // behind start: silent
        drain();

        // longest period: one short of it stays open, the full period closes
        program_period(PERIOD_MAX);
        base = tracker.win_start;
        send_event(make_frame(1'b0, '0, base + PERIOD_MAX - 1));
        send_event(make_frame(1'b0, '0, base + PERIOD_MAX));
        drain();

        // random phases; period zero reports on each item not behind the window
        // start, and its long report-side hold backs the block up into the frame side
        run_phase(32'd1, 1'b0, 1'b0, 0);
        run_phase('0, 1'b1, 1'b1, 60);
        run_phase($urandom_range(20, 400), 1'b1, 1'b0, 0);
        run_phase($urandom_range(5000, 100000), 1'b0, 1'b1, 0);
        run_phase($urandom(), 1'b0, 1'b0, 0);

        // top of both time fields; closes whatever window is open
        sender_calm = 1'b0;
        send_event(make_frame(1'b1, '1, '1));
        drain();

        if (tracker.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // run limit, several times the slowest legal run
    initial begin : watchdog
        #8_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
